/* hdl/bors_pkg.sv */
// shared constants, codes and types for the best overlap rectangle selector
// no dependencies; imported by every module of the block except bors_ram

package bors_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int EDGE_W      = 16;
  localparam int AREA_W      = 2 * EDGE_W;
  localparam int DIST_W      = EDGE_W + 1;
  localparam int SQ_W        = 2 * DIST_W;
  localparam int D2_W        = SQ_W + 1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] bottom;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    rect_t                  rect;
    logic signed [EDGE_W:0] cx;
    logic signed [EDGE_W:0] cy;
  } win_t;

  typedef struct packed {
    logic          vld;
    logic          last;
    logic [AW-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [AREA_W-1:0] area;
    logic [SQ_W-1:0]   dxsq;
    logic [SQ_W-1:0]   dysq;
  } eval_t;

endpackage

/* hdl/bors_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module bors_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bors_eval.sv */
// per-entry datapath: clipped overlap size and center distance, then the products
// depends on bors_pkg; fed by the table ram read data

module bors_eval
  import bors_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  tag_t  tag_in,
  input  rect_t rd_rect,
  input  win_t  win,
  output eval_t ev
);

  tag_t                   t0_r;
  tag_t                   t1_r;
  eval_t                  ev_r;
  logic [EDGE_W-1:0]      w_r;
  logic [EDGE_W-1:0]      h_r;
  logic [DIST_W-1:0]      ax_r;
  logic [DIST_W-1:0]      ay_r;

  logic signed [EDGE_W:0]   min_rt, max_l, min_b, max_t, dw, dh;
  logic signed [EDGE_W:0]   lo_x, hi_x, lo_y, hi_y, cl_x, cl_y;
  logic signed [EDGE_W+1:0] dx, dy, ndx, ndy;
  logic [EDGE_W-1:0]        w_nxt, h_nxt;
  logic [DIST_W-1:0]        ax_nxt, ay_nxt;

  always_comb begin
    min_rt = (win.rect.right < rd_rect.right) ? 17'(win.rect.right) : 17'(rd_rect.right);
    max_l = (win.rect.left > rd_rect.left) ? 17'(win.rect.left) : 17'(rd_rect.left);
    min_b = (win.rect.bottom < rd_rect.bottom) ? 17'(win.rect.bottom)
                                               : 17'(rd_rect.bottom);
    max_t = (win.rect.top > rd_rect.top) ? 17'(win.rect.top) : 17'(rd_rect.top);
    dw    = min_rt - max_l;
    dh    = min_b - max_t;
    w_nxt = (dw > 0) ? dw[EDGE_W-1:0] : '0;
    h_nxt = (dh > 0) ? dh[EDGE_W-1:0] : '0;

    // doubled clamp bounds
    lo_x = $signed({rd_rect.left, 1'b0});
    hi_x = $signed({rd_rect.right, 1'b0});
    lo_y = $signed({rd_rect.top, 1'b0});
    hi_y = $signed({rd_rect.bottom, 1'b0});
    if (win.cx < lo_x) begin
      cl_x = lo_x;
    end else if (win.cx < hi_x) begin
      cl_x = win.cx;
    end else begin
      cl_x = hi_x;
    end
    if (win.cy < lo_y) begin
      cl_y = lo_y;
    end else if (win.cy < hi_y) begin
      cl_y = win.cy;
    end else begin
      cl_y = hi_y;
    end
    dx     = 18'(win.cx) - 18'(cl_x);
    dy     = 18'(win.cy) - 18'(cl_y);
    ndx    = -dx;
    ndy    = -dy;
    ax_nxt = dx[EDGE_W+1] ? ndx[DIST_W-1:0] : dx[DIST_W-1:0];
    ay_nxt = dy[EDGE_W+1] ? ndy[DIST_W-1:0] : dy[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r        <= '0;
      t1_r        <= '0;
      ev_r.tag    <= '0;
    end else begin
      t0_r     <= tag_in;
      t1_r     <= t0_r;
      ev_r.tag <= t1_r;
    end
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    ev_r.area <= AREA_W'(w_r) * AREA_W'(h_r);
    ev_r.dxsq <= SQ_W'(ax_r) * SQ_W'(ax_r);
    ev_r.dysq <= SQ_W'(ay_r) * SQ_W'(ay_r);
  end

  assign ev = ev_r;

endmodule

/* hdl/bors_pick.sv */
// running best-overlap and nearest-entry tracker, result registers
// depends on bors_pkg; fed by bors_eval

module bors_pick
  import bors_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              empty,
  input  eval_t             ev,
  output logic              out_valid,
  output logic              out_found,
  output logic [SLOT_W-1:0] out_chosen_slot,
  output logic              out_by_overlap
);

  logic [AREA_W-1:0] best_area_r, best_area_nxt;
  logic [AW-1:0]     area_idx_r, area_idx_nxt;
  logic [D2_W-1:0]   best_d_r, best_d_nxt;
  logic [AW-1:0]     dist_idx_r, dist_idx_nxt;
  logic              have_r;
  logic [D2_W-1:0]   d2;
  logic              take_a, take_d;

  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_by_overlap_r;

  always_comb begin
    d2            = D2_W'(ev.dxsq) + D2_W'(ev.dysq);
    take_a        = ev.tag.vld && (ev.area > best_area_r);
    take_d        = ev.tag.vld && (!have_r || (d2 < best_d_r));
    best_area_nxt = take_a ? ev.area : best_area_r;
    area_idx_nxt  = take_a ? ev.tag.idx : area_idx_r;
    best_d_nxt    = take_d ? d2 : best_d_r;
    dist_idx_nxt  = take_d ? ev.tag.idx : dist_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r           <= 1'b0;
      best_area_r      <= '0;
      out_valid_r      <= 1'b0;
      out_found_r      <= 1'b0;
      out_slot_r       <= '0;
      out_by_overlap_r <= 1'b0;
    end else begin
      if (clr) begin
        have_r      <= 1'b0;
        best_area_r <= '0;
      end else begin
        have_r      <= have_r || ev.tag.vld;
        best_area_r <= best_area_nxt;
      end
      area_idx_r  <= area_idx_nxt;
      best_d_r    <= best_d_nxt;
      dist_idx_r  <= dist_idx_nxt;
      out_valid_r <= empty || (ev.tag.vld && ev.tag.last);
      if (empty) begin
        out_found_r      <= 1'b0;
        out_slot_r       <= '0;
        out_by_overlap_r <= 1'b0;
      end else begin
        out_found_r      <= 1'b1;
        out_by_overlap_r <= (best_area_nxt != '0);
        out_slot_r       <= (best_area_nxt != '0) ? SLOT_W'(area_idx_nxt)
                                                  : SLOT_W'(dist_idx_nxt);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_slot = out_slot_r;
  assign out_by_overlap  = out_by_overlap_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ev.tag.vld && ev.tag.last) |=> out_valid_r)
    else $error("last entry did not produce a result");

  a_overlap_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_by_overlap_r) |-> out_found_r)
    else $error("overlap result without found");

  a_clear_on_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> !ev.tag.vld)
    else $error("new query while entries still in flight");

endmodule

/* hdl/best_overlap_rect_selector.sv */
// top level: command sequencer, window and count registers, table ram, eval and pick
// depends on bors_pkg, bors_ram, bors_eval, bors_pick
//
// channel   direction  handshake                     payload
// input     in         start high while busy low     in_action, in_entry_slot, in_rect_*
// result    out        out_valid strobe, one cycle   out_found, out_chosen_slot, out_by_overlap
// config    in         cfg_valid and cfg_ready       cfg_entries_in_use
//
// a load item is written to the table as it is taken and never raises busy; a query walks the entries
// in use in order, its result strobing once the last entry leaves the pick stage; an empty query skips the table
// the single table read port walks one entry per cycle through a four-stage pipeline
// synchronous reset clears the entry count and control; table contents stay undefined
// the receiver cannot stall; busy stays high until the result has been shown

module best_overlap_rect_selector
  import bors_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [SLOT_W-1:0]        in_entry_slot,
  input  logic signed [EDGE_W-1:0] in_rect_left,
  input  logic signed [EDGE_W-1:0] in_rect_top,
  input  logic signed [EDGE_W-1:0] in_rect_right,
  input  logic signed [EDGE_W-1:0] in_rect_bottom,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [SLOT_W-1:0]        out_chosen_slot,
  output logic                     out_by_overlap,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_entries_in_use
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   idx_r;
  logic [CFG_W-1:0] cfg_count_r;
  win_t            win_r;

  logic            accept, acc_query, acc_load;
  logic [CW-1:0]   cnt_in;
  logic            last_issue;
  logic            run;
  logic            ram_we;
  rect_t           in_rect;
  rect_t           rd_rect;
  logic [RECT_W-1:0] rd_data;
  tag_t            tag_issue;
  eval_t           ev;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign accept     = start && !busy;
  assign acc_query  = accept && (in_action == ACT_QUERY);
  assign acc_load   = accept && (in_action == ACT_LOAD);
  assign cnt_in     = (int'(cfg_count_r) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(cfg_count_r);
  assign run        = (state_r == ST_RUN);
  assign last_issue = (CW'(idx_r) == (cnt_r - CW'(1)));
  assign ram_we     = acc_load && (int'(in_entry_slot) < MAX_ENTRIES);

  assign in_rect.left   = in_rect_left;
  assign in_rect.top    = in_rect_top;
  assign in_rect.right  = in_rect_right;
  assign in_rect.bottom = in_rect_bottom;

  assign tag_issue.vld  = run;
  assign tag_issue.last = last_issue;
  assign tag_issue.idx  = idx_r;

  assign rd_rect = rect_t'(rd_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_count_r <= cfg_entries_in_use;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc_query) begin
            cnt_r   <= cnt_in;
            idx_r   <= '0;
            state_r <= (cnt_in == '0) ? ST_WAIT : ST_RUN;
          end
        end
        ST_RUN: begin
          idx_r <= idx_r + AW'(1);
          if (last_issue) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_valid) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (acc_query) begin
      win_r.rect <= in_rect;
      win_r.cx   <= 17'(in_rect_left) + 17'(in_rect_right);
      win_r.cy   <= 17'(in_rect_top) + 17'(in_rect_bottom);
    end
  end

  bors_ram #(
    .WIDTH(RECT_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_slot)),
    .wdata (RECT_W'(in_rect)),
    .re    (run),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  bors_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag_issue),
    .rd_rect (rd_rect),
    .win     (win_r),
    .ev      (ev)
  );

  bors_pick u_pick (
    .clk             (clk),
    .rst_n           (rst_n),
    .clr             (acc_query),
    .empty           (acc_query && (cnt_in == '0)),
    .ev              (ev),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_by_overlap  (out_by_overlap)
  );

  a_result_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_WAIT))
    else $error("result outside wait state");

  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_query && (cnt_in == '0)) |=> (out_valid && !out_found))
    else $error("empty query did not report not found");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (CW'(idx_r) < cnt_r))
    else $error("entry index beyond count");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for best_overlap_rect_selector: directed table, then random phases
// a scoreboard predicts untagged picks from a shadow of the display table and entry count
// depends on bors_pkg and the best_overlap_rect_selector rtl

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bors_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 40;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              by_overlap;
  } pick_t;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg_val;
    logic              act;
    logic [SLOT_W-1:0] slot;
    rect_t             r;
    bit                typed;
    pick_t             res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_action;
  logic [SLOT_W-1:0]        in_entry_slot;
  logic signed [EDGE_W-1:0] in_rect_left;
  logic signed [EDGE_W-1:0] in_rect_top;
  logic signed [EDGE_W-1:0] in_rect_right;
  logic signed [EDGE_W-1:0] in_rect_bottom;
  logic                     out_valid;
  logic                     out_found;
  logic [SLOT_W-1:0]        out_chosen_slot;
  logic                     out_by_overlap;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_entries_in_use;

  // expectation tagging travels with each item
  logic  typed_on;
  pick_t typed_pick;

  rect_t            display_shadow [MAX_ENTRIES] = '{default: '0};
  logic [CFG_W-1:0] count_shadow = '0;
  rect_t            stim_table [MAX_ENTRIES];
  pick_t            expected_picks [$];
  dir_row_t         dir_rows [$];
  bit               no_gaps;

  int n_items, n_queries, n_loads, n_cfg, n_checked, errors, cycle_count;

  best_overlap_rect_selector uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_entry_slot      (in_entry_slot),
    .in_rect_left       (in_rect_left),
    .in_rect_top        (in_rect_top),
    .in_rect_right      (in_rect_right),
    .in_rect_bottom     (in_rect_bottom),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_chosen_slot    (out_chosen_slot),
    .out_by_overlap     (out_by_overlap),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint clamp2(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v < hi) return v;
    return hi;
  endfunction

  function automatic pick_t pick_display(rect_t w, logic [CFG_W-1:0] cnt);
    pick_t  p;
    int     n;
    int     best;
    longint wl, wt, wr, wb, el, et, er, eb;
    longint wd, ht, area, best_area, cx, cy, dx, dy, d, best_d;
    p = '0;
    n = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : int'(cnt);
    if (n == 0) return p;
    wl = $signed(w.left);
    wt = $signed(w.top);
    wr = $signed(w.right);
    wb = $signed(w.bottom);
    best = 0;
    best_area = 0;
    for (int i = 0; i < n; i++) begin
      el = $signed(display_shadow[i].left);
      et = $signed(display_shadow[i].top);
      er = $signed(display_shadow[i].right);
      eb = $signed(display_shadow[i].bottom);
      wd = ((wr < er) ? wr : er) - ((wl > el) ? wl : el);
      ht = ((wb < eb) ? wb : eb) - ((wt > et) ? wt : et);
      if (wd < 0) wd = 0;
      if (ht < 0) ht = 0;
      area = wd * ht;
      if (area > best_area) begin
        best_area = area;
        best = i;
      end
    end
    p.found = 1'b1;
    if (best_area > 0) begin
      p.slot = best[SLOT_W-1:0];
      p.by_overlap = 1'b1;
      return p;
    end
    // nothing overlaps: nearest entry to the doubled window center
    cx = wl + wr;
    cy = wt + wb;
    best = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      el = $signed(display_shadow[i].left);
      et = $signed(display_shadow[i].top);
      er = $signed(display_shadow[i].right);
      eb = $signed(display_shadow[i].bottom);
      dx = cx - clamp2(cx, 2 * el, 2 * er);
      dy = cy - clamp2(cy, 2 * et, 2 * eb);
      d = dx * dx + dy * dy;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    p.slot = best[SLOT_W-1:0];
    p.by_overlap = 1'b0;
    return p;
  endfunction

  function automatic rect_t mk_rect(int lft, int tp, int rgt, int btm);
    rect_t r;
    r.left   = EDGE_W'(lft);
    r.top    = EDGE_W'(tp);
    r.right  = EDGE_W'(rgt);
    r.bottom = EDGE_W'(btm);
    return r;
  endfunction

  function automatic logic signed [EDGE_W-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    int    mode;
    int    x, y;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      // small clustered rects so overlaps and ties are frequent
      x = int'($urandom_range(0, 80)) - 40;
      y = int'($urandom_range(0, 80)) - 40;
      r = mk_rect(x, y, x + int'($urandom_range(0, 35)) - 5,
                  y + int'($urandom_range(0, 35)) - 5);
    end else if (mode <= 7) begin
      r = {$urandom, $urandom};
    end else if (mode == 8) begin
      r.left   = corner_coord();
      r.top    = corner_coord();
      r.right  = corner_coord();
      r.bottom = corner_coord();
    end else begin
      r = stim_table[$urandom_range(0, MAX_ENTRIES - 1)];
    end
    return r;
  endfunction

  function automatic void add_item(logic act, int slot, rect_t r, bit typed, pick_t res);
    dir_row_t row;
    row = '{default: '0};
    row.act   = act;
    row.slot  = SLOT_W'(slot);
    row.r     = r;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int v);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = CFG_W'(v);
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(logic act, logic [SLOT_W-1:0] slot, rect_t r, bit typed,
                           pick_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_entry_slot  <= slot;
    in_rect_left   <= r.left;
    in_rect_top    <= r.top;
    in_rect_right  <= r.right;
    in_rect_bottom <= r.bottom;
    typed_on       <= typed;
    typed_pick     <= res;
    if (act == ACT_LOAD) stim_table[slot] = r;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_entries_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : scoreboard
    rect_t w;
    pick_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_picks.size() == 0) begin
          errors++;
          $display("%0t: unexpected pick: found=%0d slot=%0d by_overlap=%0d", $time,
                   out_found, out_chosen_slot, out_by_overlap);
        end else begin
          want = expected_picks.pop_front();
          n_checked++;
          if (out_found !== want.found || out_chosen_slot !== want.slot ||
              out_by_overlap !== want.by_overlap) begin
            errors++;
            $display("%0t: pick mismatch: expected found=%0d slot=%0d by_overlap=%0d",
                     $time, want.found, want.slot, want.by_overlap);
            $display("%0t: pick mismatch: actual   found=%0d slot=%0d by_overlap=%0d",
                     $time, out_found, out_chosen_slot, out_by_overlap);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        count_shadow = cfg_entries_in_use;
        n_cfg++;
      end
      if (start && !busy) begin
        w.left   = in_rect_left;
        w.top    = in_rect_top;
        w.right  = in_rect_right;
        w.bottom = in_rect_bottom;
        n_items++;
        if (in_action == ACT_LOAD) begin
          n_loads++;
          if (in_entry_slot < MAX_ENTRIES) display_shadow[in_entry_slot] = w;
        end else begin
          n_queries++;
          want = typed_on ? typed_pick : pick_display(w, count_shadow);
          expected_picks.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rect_t r;
    int    waited;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_action          <= ACT_LOAD;
    in_entry_slot      <= '0;
    in_rect_left       <= '0;
    in_rect_top        <= '0;
    in_rect_right      <= '0;
    in_rect_bottom     <= '0;
    cfg_valid          <= 1'b0;
    cfg_entries_in_use <= '0;
    typed_on           <= 1'b0;
    typed_pick         <= '0;
    no_gaps = 1'b0;
    foreach (stim_table[k]) stim_table[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table after reset, extremes, inverted and zero-size rects, count changes
    add_item(ACT_QUERY, 0, mk_rect(-32768, -32768, 32767, 32767), 1'b1,
             pick_t'{1'b0, 4'd0, 1'b0});
    add_item(ACT_LOAD, 0, mk_rect(-32768, -32768, 32767, 32767), 1'b0, '0);
    add_item(ACT_LOAD, 1, mk_rect(0, 0, 10, 10), 1'b0, '0);
    add_item(ACT_LOAD, 2, mk_rect(100, 100, 50, 50), 1'b0, '0);
    add_item(ACT_LOAD, 3, mk_rect(32767, 32767, -32768, -32768), 1'b0, '0);
    add_item(ACT_LOAD, 15, mk_rect(-32768, 32767, -1, 0), 1'b0, '0);
    add_cfg(1);
    add_item(ACT_QUERY, 9, mk_rect(0, 0, 1, 1), 1'b1, pick_t'{1'b1, 4'd0, 1'b1});
    add_item(ACT_QUERY, 0, mk_rect(5, 5, 0, 0), 1'b1, pick_t'{1'b1, 4'd0, 1'b0});
    add_cfg(4);
    add_item(ACT_QUERY, 0, mk_rect(0, 0, 10, 10), 1'b0, '0);
    add_item(ACT_QUERY, 15, mk_rect(200, 200, 300, 300), 1'b0, '0);
    add_item(ACT_QUERY, 0, mk_rect(-32768, -32768, 32767, 32767), 1'b0, '0);
    add_item(ACT_QUERY, 0, mk_rect(32767, 32767, -32768, -32768), 1'b0, '0);
    add_item(ACT_QUERY, 0, mk_rect(7, 7, 7, 7), 1'b0, '0);
    add_cfg(2);
    add_item(ACT_QUERY, 0, mk_rect(10, 0, 20, 10), 1'b0, '0);
    add_item(ACT_LOAD, 0, mk_rect(-10, -10, -5, -5), 1'b0, '0);
    add_item(ACT_QUERY, 0, mk_rect(20, 20, 30, 30), 1'b0, '0);
    add_item(ACT_QUERY, 0, mk_rect(-3, -3, 3, 3), 1'b0, '0);
    add_cfg(0);
    add_item(ACT_QUERY, 0, mk_rect(0, 0, 1, 1), 1'b1, pick_t'{1'b0, 4'd0, 1'b0});
    add_cfg(4);
    add_item(ACT_QUERY, 0, mk_rect(-32768, -32768, -32768, -32768), 1'b0, '0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_count(dir_rows[k].cfg_val);
      else send_item(dir_rows[k].act, dir_rows[k].slot, dir_rows[k].r, dir_rows[k].typed,
                     dir_rows[k].res);
    end

    // fill every slot so any count is legal from here on
    for (int k = 0; k < MAX_ENTRIES; k++) send_item(ACT_LOAD, SLOT_W'(k), rand_rect(), 1'b0, '0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: write_count(5'd0);
        1: write_count(5'd1);
        2: write_count(5'd16);
        3: write_count(5'd31);
        4: write_count(5'd17);
        default: write_count(CFG_W'($urandom_range(0, 31)));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = rand_rect();
        if ($urandom_range(0, 9) < 6)
          send_item(ACT_QUERY, SLOT_W'($urandom_range(0, 15)), r, 1'b0, '0);
        else
          send_item(ACT_LOAD, SLOT_W'($urandom_range(0, 15)), r, 1'b0, '0);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (expected_picks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_picks.size() != 0) begin
      errors += expected_picks.size();
      $display("%0t: %0d expected picks never arrived", $time, expected_picks.size());
    end

    $display("covered %0d items (%0d queries, %0d loads) over %0d entry count writes",
             n_items, n_queries, n_loads, n_cfg);
    $display("compared %0d picks, %0d errors", n_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
